FILE: hdl/rlh_pkg.sv
// Package for the run-length histogram: shared constants, register indexes
// and the command and status types between controller and datapath.
// No dependencies.
`default_nettype none

package rlh_pkg;

    localparam int RLH_NUM_BINS    = 128;
    localparam int RLH_COUNT_WIDTH = 32;

    localparam int RLH_SAMPLE_W = 32;
    localparam int RLH_INDEX_W  = 7;
    localparam int RLH_COUNT_W  = 32;
    localparam int RLH_RUN_W    = 7;
    localparam int RLH_S_DATA_W = 40;
    localparam int RLH_M_DATA_W = 40;
    localparam int RLH_ADDR_W   = 3;

    localparam logic RLH_REG_THRESHOLD_ENABLE = 1'b0;
    localparam logic RLH_REG_THRESHOLD        = 1'b1;

    localparam logic RLH_REQ_SAMPLE = 1'b0;
    localparam logic RLH_REQ_READ   = 1'b1;

    typedef struct packed {
        logic clear;
        logic accept;
        logic commit;
    } rlh_cmd_t;

    typedef struct packed {
        logic clear_last;
    } rlh_sts_t;

endpackage

`default_nettype wire

FILE: hdl/run_length_histogram.sv
// Top level of the run-length histogram: configuration registers on the APB
// port and the stream ports. Depends on rlh_pkg, rlh_ctrl and rlh_datapath.
//
// After reset the block clears its histogram memory, one bin a cycle, and
// accepts no request until that pass is done; the configuration port works
// throughout. Each request first reads its bin from the single-port
// histogram memory and then updates the run counter, the result register
// and, when a run closes, the bin of that run. A result that is not taken
// holds back the update of the next request, not its acceptance.
`default_nettype none

module run_length_histogram #(
    parameter int NUM_BINS    = rlh_pkg::RLH_NUM_BINS,
    parameter int COUNT_WIDTH = rlh_pkg::RLH_COUNT_WIDTH
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // [31:0] sample, [38:32] bin_index, [39] zero
    input  wire logic [rlh_pkg::RLH_S_DATA_W-1:0]    s_tdata,
    // [0] req_type
    input  wire logic                                s_tuser,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // [31:0] bin_count, [38:32] run_length, [39] zero
    output logic [rlh_pkg::RLH_M_DATA_W-1:0]         m_tdata,
    // [0] run_closed
    output logic                                     m_tuser,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [rlh_pkg::RLH_ADDR_W-1:0]      paddr,
    input  wire logic [31:0]                         pwdata,
    output logic [31:0]                              prdata,
    output logic                                     pready
);
    import rlh_pkg::*;

    logic                    threshold_enable_reg;
    logic [RLH_SAMPLE_W-1:0] threshold_reg;
    logic                    cfg_write;
    rlh_cmd_t                cmd;
    rlh_sts_t                sts;
    logic [RLH_COUNT_W-1:0]  bin_count;
    logic [RLH_RUN_W-1:0]    run_length;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_enable_reg <= 1'b0;
            threshold_reg        <= '0;
        end else if (cfg_write) begin
            case (paddr[2])
                RLH_REG_THRESHOLD_ENABLE: threshold_enable_reg <= pwdata[0];
                RLH_REG_THRESHOLD:        threshold_reg        <= pwdata;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            RLH_REG_THRESHOLD_ENABLE: prdata = {31'd0, threshold_enable_reg};
            RLH_REG_THRESHOLD:        prdata = threshold_reg;
            default:                  prdata = '0;
        endcase
    end

    rlh_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    rlh_datapath #(
        .NUM_BINS    (NUM_BINS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .sts              (sts),
        .req_type         (s_tuser),
        .sample           (s_tdata[31:0]),
        .bin_index        (s_tdata[38:32]),
        .threshold_enable (threshold_enable_reg),
        .threshold        (threshold_reg),
        .bin_count        (bin_count),
        .run_length       (run_length),
        .run_closed       (m_tuser)
    );

    assign m_tdata = {1'b0, run_length, bin_count};

endmodule

`default_nettype wire

FILE: hdl/rlh_datapath.sv
// Datapath of the run-length histogram: histogram memory, run counter,
// hit detection and the result register. Depends on rlh_pkg.
`default_nettype none

module rlh_datapath #(
    parameter int NUM_BINS    = rlh_pkg::RLH_NUM_BINS,
    parameter int COUNT_WIDTH = rlh_pkg::RLH_COUNT_WIDTH
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire rlh_pkg::rlh_cmd_t                 cmd,
    output rlh_pkg::rlh_sts_t                      sts,
    input  wire logic                              req_type,
    input  wire logic [rlh_pkg::RLH_SAMPLE_W-1:0]  sample,
    input  wire logic [rlh_pkg::RLH_INDEX_W-1:0]   bin_index,
    input  wire logic                              threshold_enable,
    input  wire logic [rlh_pkg::RLH_SAMPLE_W-1:0]  threshold,
    output logic [rlh_pkg::RLH_COUNT_W-1:0]        bin_count,
    output logic [rlh_pkg::RLH_RUN_W-1:0]          run_length,
    output logic                                   run_closed
);
    import rlh_pkg::*;

    localparam int BIN_W = $clog2(NUM_BINS);
    localparam int IDX_EXT_W = BIN_W + RLH_INDEX_W;
    localparam int RUN_EXT_W = BIN_W + RLH_RUN_W;
    localparam int CNT_EXT_W = COUNT_WIDTH + RLH_COUNT_W;
    localparam logic [BIN_W-1:0] RUN_MAX = BIN_W'(NUM_BINS - 1);

    logic [COUNT_WIDTH-1:0] hist_mem [NUM_BINS];

    logic [BIN_W-1:0]       clr_addr_reg, clr_addr_next;
    logic [BIN_W-1:0]       run_reg, run_next;
    logic                   req_reg;
    logic                   hit_reg;
    logic                   in_range_reg;
    logic [BIN_W-1:0]       addr_reg;
    logic [COUNT_WIDTH-1:0] rd_data_reg;
    logic [RLH_COUNT_W-1:0] bin_count_reg, bin_count_next;
    logic [RLH_RUN_W-1:0]   run_length_reg, run_length_next;
    logic                   run_closed_reg, run_closed_next;

    logic [IDX_EXT_W-1:0]   idx_ext;
    logic                   idx_ok;
    logic [BIN_W-1:0]       rd_addr;
    logic                   hit;
    logic                   closed;
    logic [COUNT_WIDTH-1:0] inc_count;
    logic [COUNT_WIDTH-1:0] count_full;
    logic [CNT_EXT_W-1:0]   count_ext;
    logic [RUN_EXT_W-1:0]   run_ext;
    logic                   mem_we;
    logic [BIN_W-1:0]       mem_waddr;
    logic [COUNT_WIDTH-1:0] mem_wdata;

    always_comb begin
        idx_ext = IDX_EXT_W'(bin_index);
        idx_ok  = idx_ext < IDX_EXT_W'(NUM_BINS);
        rd_addr = (req_type == RLH_REQ_READ) ? idx_ext[BIN_W-1:0] : run_reg;
        hit     = threshold_enable ? ($signed(sample) > $signed(threshold))
                                   : (sample == '0);
    end

    always_comb begin
        closed    = (req_reg == RLH_REQ_SAMPLE) && !hit_reg;
        inc_count = (rd_data_reg == '1) ? rd_data_reg : rd_data_reg + 1'b1;
        if (closed) begin
            count_full = inc_count;
        end else if ((req_reg == RLH_REQ_READ) && in_range_reg) begin
            count_full = rd_data_reg;
        end else begin
            count_full = '0;
        end
        run_next = run_reg;
        if (cmd.commit && (req_reg == RLH_REQ_SAMPLE)) begin
            if (!hit_reg) begin
                run_next = '0;
            end else if (run_reg != RUN_MAX) begin
                run_next = run_reg + 1'b1;
            end
        end
        count_ext = CNT_EXT_W'(count_full);
        bin_count_next = (count_ext > CNT_EXT_W'({RLH_COUNT_W{1'b1}}))
                       ? {RLH_COUNT_W{1'b1}} : count_ext[RLH_COUNT_W-1:0];
        run_ext = RUN_EXT_W'(run_next);
        run_length_next = (run_ext > RUN_EXT_W'({RLH_RUN_W{1'b1}}))
                        ? {RLH_RUN_W{1'b1}} : run_ext[RLH_RUN_W-1:0];
        run_closed_next = closed;
    end

    always_comb begin
        clr_addr_next = cmd.clear ? clr_addr_reg + 1'b1 : clr_addr_reg;
        mem_we        = cmd.clear || (cmd.commit && closed);
        mem_waddr     = cmd.clear ? clr_addr_reg : addr_reg;
        mem_wdata     = cmd.clear ? '0 : inc_count;
        sts.clear_last = clr_addr_reg == RUN_MAX;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
            run_reg      <= '0;
        end else begin
            clr_addr_reg <= clr_addr_next;
            run_reg      <= run_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            hist_mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.accept) begin
            rd_data_reg  <= hist_mem[rd_addr];
            addr_reg     <= rd_addr;
            req_reg      <= req_type;
            hit_reg      <= hit;
            in_range_reg <= idx_ok;
        end
        if (cmd.commit) begin
            bin_count_reg  <= bin_count_next;
            run_length_reg <= run_length_next;
            run_closed_reg <= run_closed_next;
        end
    end

    assign bin_count  = bin_count_reg;
    assign run_length = run_length_reg;
    assign run_closed = run_closed_reg;

endmodule

`default_nettype wire

FILE: hdl/rlh_ctrl.sv
// Controller of the run-length histogram: clearing pass, request sequencing
// and the result valid flag. Depends on rlh_pkg.
`default_nettype none

module rlh_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output rlh_pkg::rlh_cmd_t      cmd,
    input  wire rlh_pkg::rlh_sts_t sts
);
    import rlh_pkg::*;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_EXEC  = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       m_tvalid_reg, m_tvalid_next;

    always_comb begin
        s_tready   = state_reg == ST_IDLE;
        cmd.clear  = state_reg == ST_CLEAR;
        cmd.accept = s_tvalid && s_tready;
        cmd.commit = (state_reg == ST_EXEC) && (!m_tvalid_reg || m_tready);

        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (sts.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (cmd.accept) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (cmd.commit) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase

        if (cmd.commit) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;

`ifndef NO_ASSERTIONS
    a_accept_to_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_EXEC))
        else $error("Accepted request did not move to execution.");
    a_commit_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> m_tvalid)
        else $error("Committed result is not presented.");
    a_no_accept_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !s_tready && !cmd.commit)
        else $error("Request handled during the clearing pass.");
    a_commit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> (!m_tvalid || m_tready))
        else $error("Result overwritten before it was taken.");
`endif

endmodule

`default_nettype wire
